// File: rtl/dccp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccp_pkg: shared types and constants
// Line-bit patterns, character codes and the command handed from the
// front end to the back end of the packer.
// ----------------------------------------------------------------------------
package dccp_pkg;

   localparam logic [7:0]  CHAR_ZERO = 8'h30;
   localparam logic [7:0]  CHAR_ONE  = 8'h31;
   localparam logic [15:0] FILL_WORD = 16'h5555;
   localparam logic [1:0]  ONE_PAIR  = 2'b01;
   localparam logic [3:0]  ZERO_BITS = 4'b0011;
   localparam int          WORD_W    = 16;
   localparam int          CMD_DEPTH = 4;

   // Up to two built words, then a run of fill words counted separately.
   typedef struct packed {
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
      logic [1:0]        word_cnt;
      logic              last;
   } cmd_type;

endpackage

// File: rtl/dccp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccp_front: character encoder and word builder
// Packs line bits of each accepted character into the current word, builds
// the finishing word on the last character and counts the fill words owed.
// ----------------------------------------------------------------------------
module dccp_front
   import dccp_pkg::*;
#(
   parameter int MAX_FRAMES = 16,
   parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       char_code,
   input  logic             end_of_string,
   input  logic [4:0]       frame_target,
   output logic             cmd_push,
   output cmd_type          cmd,
   output logic [CNT_W-1:0] cmd_pad
);

   localparam int TW = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

   logic [WORD_W-1:0] cell_ff, cell_in;
   logic [3:0]        filled_ff, filled_in;
   logic [CNT_W-1:0]  frames_ff, frames_in;

   logic              is_one, is_zero;
   logic [WORD_W+1:0] ext_one;
   logic [WORD_W+3:0] ext_zero;
   logic              gen_v;
   logic [WORD_W-1:0] gen_word;
   logic [WORD_W-1:0] cell_n;
   logic [3:0]        filled_n;
   logic              fin_v;
   logic [WORD_W-1:0] fin_word;
   logic [4:0]        fin_shift;
   logic [CNT_W-1:0]  fs_a, fs_b;
   logic [TW-1:0]     tgt, fs_w;
   logic [CNT_W-1:0]  pad;

   assign is_one   = (char_code == CHAR_ONE);
   assign is_zero  = (char_code == CHAR_ZERO);
   assign ext_one  = {cell_ff, ONE_PAIR};
   assign ext_zero = {cell_ff, ZERO_BITS};

   always_comb begin
      gen_v    = 1'b0;
      gen_word = ext_one[WORD_W-1:0];
      cell_n   = cell_ff;
      filled_n = filled_ff;
      if (is_one) begin
         if (filled_ff == 4'd14) begin
            gen_v    = 1'b1;
            gen_word = ext_one[WORD_W-1:0];
            cell_n   = '0;
            filled_n = '0;
         end else begin
            cell_n   = ext_one[WORD_W-1:0];
            filled_n = filled_ff + 4'd2;
         end
      end else if (is_zero) begin
         priority if (filled_ff == 4'd14) begin
            // straddle: 00 closes this word, 11 opens the next
            gen_v    = 1'b1;
            gen_word = ext_zero[WORD_W+1:2];
            cell_n   = WORD_W'(2'b11);
            filled_n = 4'd2;
         end else if (filled_ff == 4'd12) begin
            gen_v    = 1'b1;
            gen_word = ext_zero[WORD_W-1:0];
            cell_n   = '0;
            filled_n = '0;
         end else begin
            cell_n   = ext_zero[WORD_W-1:0];
            filled_n = filled_ff + 4'd4;
         end
      end
   end

   // Complete a partial word with 01 pairs below its line bits.
   assign fin_v     = end_of_string && (filled_n != 4'd0);
   assign fin_shift = 5'd16 - {1'b0, filled_n};
   assign fin_word  = (cell_n << fin_shift) | (FILL_WORD & (16'hFFFF >> filled_n));

   assign fs_a = (gen_v && frames_ff < MAX_CNT) ? frames_ff + CNT_W'(1) : frames_ff;
   assign fs_b = (fin_v && fs_a < MAX_CNT) ? fs_a + CNT_W'(1) : fs_a;
   assign fs_w = TW'(fs_b);

   always_comb begin
      tgt = TW'(frame_target);
      if (tgt > TW'(MAX_FRAMES)) begin
         tgt = TW'(MAX_FRAMES);
      end
      pad = '0;
      if (end_of_string && tgt > fs_w) begin
         pad = CNT_W'(tgt - fs_w);
      end
   end

   assign cmd.word_a   = gen_v ? gen_word : fin_word;
   assign cmd.word_b   = fin_word;
   assign cmd.word_cnt = {1'b0, gen_v} + {1'b0, fin_v};
   assign cmd.last     = end_of_string;
   assign cmd_pad      = pad;
   assign cmd_push     = accept && (gen_v || fin_v || pad != '0);

   always_comb begin
      cell_in   = cell_ff;
      filled_in = filled_ff;
      frames_in = frames_ff;
      if (accept) begin
         if (end_of_string) begin
            cell_in   = '0;
            filled_in = '0;
            frames_in = '0;
         end else begin
            cell_in   = cell_n;
            filled_in = filled_n;
            frames_in = fs_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff   <= '0;
         filled_ff <= '0;
         frames_ff <= '0;
      end else begin
         cell_ff   <= cell_in;
         filled_ff <= filled_in;
         frames_ff <= frames_in;
      end
   end

endmodule

// File: rtl/dccp_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccp_cmd_fifo: command queue
// Small first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
module dccp_cmd_fifo
   import dccp_pkg::*;
#(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] head_data,
   output logic         full,
   output logic         empty
);

   localparam int PW = $clog2(CMD_DEPTH);

   logic [W-1:0]  mem [CMD_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == (PW+1)'(CMD_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + PW'(1) : rd_ff;
      count_in = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/dccp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccp_back: word sequencer
// Expands each queued command into its built words and fill words, written
// to the result register one word per cycle while it is empty or popped.
// ----------------------------------------------------------------------------
module dccp_back
   import dccp_pkg::*;
#(
   parameter int CNT_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   input  logic [CNT_W-1:0]  head_pad,
   output logic              head_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [WORD_W-1:0] rsp_frame_word,
   output logic              rsp_last_frame
);

   localparam int KW = CNT_W + 2;

   logic              out_v_ff, out_v_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              last_ff, last_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [KW-1:0]     total;
   logic              advance, emit, is_final;
   logic [WORD_W-1:0] sel_word;

   assign total    = KW'(head_cmd.word_cnt) + KW'(head_pad);
   assign advance  = !out_v_ff || rsp_pop;
   assign emit     = advance && head_valid;
   assign is_final = (k_ff + KW'(1) == total);
   assign head_pop = emit && is_final;

   always_comb begin
      priority if (k_ff < KW'(head_cmd.word_cnt)) begin
         sel_word = (k_ff == '0) ? head_cmd.word_a : head_cmd.word_b;
      end else begin
         sel_word = FILL_WORD;
      end
   end

   always_comb begin
      out_v_in = out_v_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      k_in     = k_ff;
      if (emit) begin
         out_v_in = 1'b1;
         word_in  = sel_word;
         last_in  = head_cmd.last && is_final;
         k_in     = is_final ? '0 : k_ff + KW'(1);
      end else if (rsp_pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         out_v_ff <= out_v_in;
         k_ff     <= k_in;
      end
   end

   assign rsp_empty      = !out_v_ff;
   assign rsp_frame_word = word_ff;
   assign rsp_last_frame = last_ff;

endmodule

// File: rtl/dcc_bit_to_ssi_frame_packer.sv
`timescale 1ns / 1ps
// Path: a completed word passes the command queue, then the result register.
// Throughput: one character per cycle while req_full is low; a packet's
//   last character adds up to MAX_FRAMES words, drained one per cycle by
//   the back-end sequencer while the result register is free or popped.
// Reset: synchronous; clears the packing state, the command queue and the
//   result register.
// ----------------------------------------------------------------------------
// dcc_bit_to_ssi_frame_packer: DCC bit string to serializer word packer
// Front end encodes characters into words, a command queue decouples it
// from the back end that emits words and fill words.
// ----------------------------------------------------------------------------
module dcc_bit_to_ssi_frame_packer
   import dccp_pkg::*;
#(
   parameter int MAX_FRAMES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_char_code,
   input  logic              req_end_of_string,
   input  logic [4:0]        req_frame_target,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [15:0]       rsp_frame_word,
   output logic              rsp_last_frame
);

   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int QW    = $bits(cmd_type) + CNT_W;

   logic             accept;
   logic             cmd_push;
   cmd_type          cmd;
   logic [CNT_W-1:0] cmd_pad;
   logic [QW-1:0]    head_data;
   logic             head_pop, q_empty;
   cmd_type          head_cmd;
   logic [CNT_W-1:0] head_pad;

   assign accept = req_push && !req_full;

   dccp_front #(
      .MAX_FRAMES (MAX_FRAMES),
      .CNT_W      (CNT_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .char_code     (req_char_code),
      .end_of_string (req_end_of_string),
      .frame_target  (req_frame_target),
      .cmd_push      (cmd_push),
      .cmd           (cmd),
      .cmd_pad       (cmd_pad)
   );

   dccp_cmd_fifo #(
      .W (QW)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({cmd_pad, cmd}),
      .pop       (head_pop),
      .head_data (head_data),
      .full      (req_full),
      .empty     (q_empty)
   );

   assign head_cmd = head_data[$bits(cmd_type)-1:0];
   assign head_pad = head_data[QW-1:$bits(cmd_type)];

   dccp_back #(
      .CNT_W (CNT_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (!q_empty),
      .head_cmd       (head_cmd),
      .head_pad       (head_pad),
      .head_pop       (head_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_frame_word (rsp_frame_word),
      .rsp_last_frame (rsp_last_frame)
   );

endmodule

// File: tb/dcc_bit_to_ssi_frame_packer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_bit_to_ssi_frame_packer_test: self-checking bench for the DCC packer
// Feeds bit-string characters through the push/full side, predicts every
// serializer word and its last flag, and checks them on the empty/pop side
// under four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module dcc_bit_to_ssi_frame_packer_test;
   import dccp_pkg::*;

   localparam int MAX_FRAMES     = 16;
   localparam int CHARS_PER_MIX  = 112;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;

   typedef struct packed {
      logic [7:0] char_code;
      logic       eos;
      logic [4:0] target;
   } dcc_char_type;

   typedef struct {
      logic [15:0] frame_word;
      logic        last;
   } line_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_end_of_string = 1'b0;
   logic [4:0]  req_frame_target = 5'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [15:0] rsp_frame_word;
   logic        rsp_last_frame;

   dcc_char_type  pend_chars[$];
   line_word_type expected_words[$];

   // packer shadow state
   logic [15:0] line_shift;
   int          line_bits;
   int          packet_words;

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int fail_count = 0;
   int chars_sent = 0;
   int packets_sent = 0;
   int words_checked = 0;
   int idle_cycles = 0;

   dcc_bit_to_ssi_frame_packer #(.MAX_FRAMES(MAX_FRAMES)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .req_frame_target  (req_frame_target),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_frame_word    (rsp_frame_word),
      .rsp_last_frame    (rsp_last_frame)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void emit_line_word(logic [15:0] w);
      line_word_type e;
      e.frame_word = w;
      e.last = 1'b0;
      expected_words.push_back(e);
      if (packet_words < MAX_FRAMES) packet_words++;
   endfunction

   function automatic void shift_line_pair(logic [1:0] pair);
      line_shift = {line_shift[13:0], pair};
      line_bits += 2;
      if (line_bits >= 16) begin
         emit_line_word(line_shift);
         line_shift = '0;
         line_bits = 0;
      end
   endfunction

   function automatic void predict_frames(dcc_char_type c);
      int            first;
      int            goal;
      line_word_type tail;
      first = expected_words.size();
      if (c.char_code == CHAR_ONE) begin
         shift_line_pair(ONE_PAIR);
      end else if (c.char_code == CHAR_ZERO) begin
         shift_line_pair(ZERO_BITS[3:2]);
         shift_line_pair(ZERO_BITS[1:0]);
      end
      if (c.eos) begin
         goal = (c.target > MAX_FRAMES) ? MAX_FRAMES : int'(c.target);
         while (line_bits != 0) shift_line_pair(ONE_PAIR);
         while (packet_words < goal) emit_line_word(FILL_WORD);
         // mark the final word of the packet, if this step made any
         if (expected_words.size() > first) begin
            tail = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
         end
         line_shift = '0;
         line_bits = 0;
         packet_words = 0;
      end
   endfunction

   // Drive one character per handshake; hold while full.
   always @(posedge clock) begin : drive_chars
      dcc_char_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_frames({req_char_code, req_end_of_string, req_frame_target});
            chars_sent++;
            if (req_end_of_string) packets_sent++;
         end
         if (req_push && req_full) begin
            req_push <= 1'b1;
         end else if (pend_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pend_chars.pop_front();
            req_char_code <= nxt.char_code;
            req_end_of_string <= nxt.eos;
            req_frame_target <= nxt.target;
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_words
      line_word_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               $error("unexpected word: frame_word %h last_frame %b",
                      rsp_frame_word, rsp_last_frame);
               fail_count++;
            end else begin
               e = expected_words.pop_front();
               if (rsp_frame_word !== e.frame_word) begin
                  $error("frame_word mismatch: expected %h, got %h",
                         e.frame_word, rsp_frame_word);
                  fail_count++;
               end
               if (rsp_last_frame !== e.last) begin
                  $error("last_frame mismatch: expected %b, got %b",
                         e.last, rsp_last_frame);
                  fail_count++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void queue_char(logic [7:0] code, logic eos, logic [4:0] target);
      dcc_char_type c;
      c.char_code = code;
      c.eos = eos;
      c.target = target;
      pend_chars.push_back(c);
   endfunction

   function automatic logic [4:0] rand_target();
      return 5'($urandom_range(31));
   endfunction

   // Queue one packet; return how many characters carry weight (bits or end).
   function automatic int queue_packet(bit noisy);
      int         len;
      int         counted;
      logic [7:0] code;
      logic       eos;
      logic [4:0] target;
      counted = 0;
      len = ($urandom_range(99) < 5) ? $urandom_range(60, 80) : $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < (noisy ? 40 : 3))
            code = 8'($urandom_range(255));
         else
            code = $urandom_range(1) ? CHAR_ONE : CHAR_ZERO;
         eos = (i == len - 1);
         target = ($urandom_range(99) < 30) ? 5'($urandom_range(2)) : rand_target();
         queue_char(code, eos, target);
         if (eos || code == CHAR_ONE || code == CHAR_ZERO) counted++;
      end
      return counted;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (pend_chars.size() != 0 || req_push || expected_words.size() != 0);
   endtask

   initial begin
      int queued;
      line_shift = '0;
      line_bits = 0;
      packet_words = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // lone one, empty end, clamped fill-only packet
      queue_char(CHAR_ONE, 1'b1, 5'd0);
      queue_char(8'hFF, 1'b1, 5'd0);
      queue_char(8'h00, 1'b1, 5'd31);
      // zero straddling a word boundary
      for (int i = 0; i < 7; i++) queue_char(CHAR_ONE, 1'b0, rand_target());
      queue_char(CHAR_ZERO, 1'b1, 5'd0);
      // ignored codes next to the bit characters, target at the maximum
      queue_char(CHAR_ZERO, 1'b0, 5'd31);
      queue_char(8'h2F, 1'b0, 5'd16);
      queue_char(8'h32, 1'b0, 5'd15);
      queue_char(CHAR_ZERO, 1'b1, 5'd16);
      queue_char(CHAR_ONE, 1'b1, 5'd17);
      queue_char(8'h80, 1'b1, 5'd1);
      wait_drained();

      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 60; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 60; end
            default: begin send_idle_pct = 8; pop_stall_pct = 8; end
         endcase
         queued = 0;
         while (queued < CHARS_PER_MIX)
            queued += queue_packet($urandom_range(99) < 10);
         // hold the next mix off until every word of this one has come out
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected words never arrived", expected_words.size());
         fail_count++;
      end
      $display("Sent %0d characters in %0d packets, checked %0d words over four gap/stall mixes",
               chars_sent, packets_sent, words_checked);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
